// ----- hdl/lsw_pkg.sv -----
// Shared types and constants for the LED line sweep sequencer.
`default_nettype none
package lsw_pkg;

  localparam int POS_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] TOP_FULL = 16'hffff;
  localparam logic [15:0] TOP_SHORT_ADJ = 16'd128;
  localparam logic [15:0] SHORT_LIMIT = 16'd256;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_LINE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_FORWARD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PIXEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY     = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] line_index;
    logic [7:0] line_cb;
    logic [7:0] line_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0] led_b_high;
    logic [7:0] led_c;
    logic [7:0] led_d;
    logic       sweep_active;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  first_line;
    logic [6:0]  last_line;
    logic        sweep_forward;
    logic [15:0] ticks_per_pixel;
    logic [31:0] start_delay;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/lsw_regs.sv -----
// Configuration register file.
`default_nettype none
module lsw_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [lsw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [lsw_pkg::CFG_DATA_W-1:0] wr_data,
  output lsw_pkg::cfg_t                       cfg
);
  import lsw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_FIRST_LINE:      cfg_nxt.first_line = wr_data[6:0];
        REG_LAST_LINE:       cfg_nxt.last_line = wr_data[6:0];
        REG_SWEEP_FORWARD:   cfg_nxt.sweep_forward = wr_data[0];
        REG_TICKS_PER_PIXEL: cfg_nxt.ticks_per_pixel = wr_data[15:0];
        REG_START_DELAY:     cfg_nxt.start_delay = wr_data[31:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_line <= '0;
      cfg_r.last_line <= '0;
      cfg_r.sweep_forward <= 1'b1;
      cfg_r.ticks_per_pixel <= '0;
      cfg_r.start_delay <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- hdl/lsw_store.sv -----
// Image line memory with a registered read port tracking the sweep position.
`default_nettype none
module lsw_store #(
  parameter int IMAGE_LINES = 128
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [6:0]                wr_index,
  input  wire logic [15:0]               wr_word,
  input  wire logic [lsw_pkg::POS_W-1:0] rd_pos,
  output logic [15:0]                    rd_word
);
  import lsw_pkg::*;

  localparam int AW = (IMAGE_LINES > 1) ? $clog2(IMAGE_LINES) : 1;

  logic [15:0]   mem [IMAGE_LINES];
  logic [15:0]   rd_data_r;
  logic          rd_in_r;
  logic          wr_in;
  logic          rd_in;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_in = 32'(wr_index) < IMAGE_LINES;
  assign rd_in = 32'(rd_pos) < IMAGE_LINES;
  assign wr_addr = wr_in ? AW'(wr_index) : '0;
  assign rd_addr = rd_in ? AW'(rd_pos) : '0;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem[wr_addr] <= wr_word;
    end
  end

  // bypass a same-cycle write so the read register always mirrors the store
  always_ff @(posedge clk) begin
    if (wr_en && wr_in && rd_in && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_word;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
    rd_in_r <= rd_in;
  end

  assign rd_word = rd_in_r ? rd_data_r : 16'h0000;

endmodule
`default_nettype wire

// ----- hdl/lsw_ctrl.sv -----
// Sweep timer, delay counting and line stepping.
`default_nettype none
module lsw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire lsw_pkg::in_item_t         item,
  input  wire lsw_pkg::cfg_t             cfg,
  input  wire logic [15:0]               rd_word,
  output logic [lsw_pkg::POS_W-1:0]      pos_nxt,
  output lsw_pkg::out_item_t             result
);
  import lsw_pkg::*;

  logic             running_r, running_nxt;
  logic [15:0]      top_r, top_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [15:0]      periods_r, periods_nxt;
  logic [15:0]      short_r, short_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] end_r, end_nxt;
  logic             fwd_r, fwd_nxt;
  logic             active_r, active_nxt;
  logic [15:0]      led_r, led_nxt;
  logic             done;
  logic [15:0]      delay_low;
  logic [15:0]      delay_high;

  assign delay_low = cfg.start_delay[15:0];
  assign delay_high = cfg.start_delay[31:16];

  always_comb begin
    if (fwd_r) begin
      done = pos_r >= end_r;
    end else begin
      done = (pos_r + POS_W'(1)) <= (end_r + POS_W'(1));
    end
  end

  always_comb begin
    running_nxt = running_r;
    top_nxt = top_r;
    tick_nxt = tick_r;
    periods_nxt = periods_r;
    short_nxt = short_r;
    pos_nxt = pos_r;
    end_nxt = end_r;
    fwd_nxt = fwd_r;
    active_nxt = active_r;
    led_nxt = led_r;
    if (acc) begin
      case (item.cmd)
        CMD_TICK: begin
          if (running_r) begin
            if (tick_r == top_r) begin
              tick_nxt = '0;
              if (periods_r != '0) begin
                periods_nxt = periods_r - 16'd1;
                if (periods_r == 16'd1) begin
                  top_nxt = short_r;
                end
              end else if (done) begin
                led_nxt = '0;
                top_nxt = TOP_FULL;
                active_nxt = 1'b0;
              end else begin
                led_nxt = rd_word;
                pos_nxt = fwd_r ? pos_r + POS_W'(1) : pos_r - POS_W'(1);
                top_nxt = cfg.ticks_per_pixel;
              end
            end else begin
              tick_nxt = tick_r + 16'd1;
            end
          end
        end
        CMD_START: begin
          led_nxt = '0;
          fwd_nxt = cfg.sweep_forward;
          if (cfg.sweep_forward) begin
            pos_nxt = POS_W'(cfg.first_line);
            end_nxt = POS_W'(cfg.last_line) + POS_W'(1);
          end else begin
            pos_nxt = POS_W'(cfg.last_line);
            end_nxt = POS_W'(cfg.first_line) - POS_W'(1);
          end
          periods_nxt = delay_high;
          if (delay_high != '0) begin
            if (delay_low < SHORT_LIMIT) begin
              top_nxt = TOP_FULL - TOP_SHORT_ADJ;
              short_nxt = delay_low + {delay_high[8:0], 7'b0};
            end else begin
              top_nxt = TOP_FULL;
              short_nxt = delay_low;
            end
          end else begin
            top_nxt = delay_low;
          end
          tick_nxt = '0;
          running_nxt = 1'b1;
          active_nxt = 1'b1;
        end
        default: begin
          led_nxt = led_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      top_r <= '0;
      tick_r <= '0;
      periods_r <= '0;
      short_r <= '0;
      pos_r <= '0;
      end_r <= '0;
      fwd_r <= 1'b1;
      active_r <= 1'b0;
      led_r <= '0;
    end else begin
      running_r <= running_nxt;
      top_r <= top_nxt;
      tick_r <= tick_nxt;
      periods_r <= periods_nxt;
      short_r <= short_nxt;
      pos_r <= pos_nxt;
      end_r <= end_nxt;
      fwd_r <= fwd_nxt;
      active_r <= active_nxt;
      led_r <= led_nxt;
    end
  end

  assign result.led_b_high = led_nxt[15:14];
  assign result.led_c = led_nxt[15:8];
  assign result.led_d = led_nxt[7:0];
  assign result.sweep_active = active_nxt;

endmodule
`default_nettype wire

// ----- hdl/lsw_out.sv -----
// Output register with a skid entry for the result channel.
`default_nettype none
module lsw_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lsw_pkg::out_item_t push_item,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lsw_pkg::out_item_t      out_item
);
  import lsw_pkg::*;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt = main_r;
    skid_nxt = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt = push_item;
      end else begin
        main_nxt = push_item;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt = push_item;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item = main_r;

endmodule
`default_nettype wire

// ----- hdl/led_line_sweep_sequencer.sv -----
// Top level of the LED line sweep sequencer.
// A result is registered in the output register, or in its skid entry while that is stalled.
// Throughput: one transaction per cycle while in_stall is low, i.e. the skid entry is empty.
// The image store read register follows the sweep position every cycle.
// Reset clears timer, sweep, LED and config state (direction forward); image store is not cleared.
`default_nettype none
module led_line_sweep_sequencer #(
  parameter int IMAGE_LINES = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lsw_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lsw_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsw_pkg::*;

  cfg_t             cfg;
  logic             acc;
  logic             full;
  logic [POS_W-1:0] pos_nxt;
  logic [15:0]      rd_word;
  out_item_t        result;

  assign cfg_ready = 1'b1;
  assign in_stall = full;
  assign acc = in_valid && !full;

  lsw_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lsw_store #(
    .IMAGE_LINES (IMAGE_LINES)
  ) u_store (
    .clk      (clk),
    .wr_en    (acc && (in_item.cmd == CMD_WRITE)),
    .wr_index (in_item.line_index),
    .wr_word  ({in_item.line_cb, in_item.line_d}),
    .rd_pos   (pos_nxt),
    .rd_word  (rd_word)
  );

  lsw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (in_item),
    .cfg     (cfg),
    .rd_word (rd_word),
    .pos_nxt (pos_nxt),
    .result  (result)
  );

  lsw_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- bench/tb_led_line_sweep_sequencer.sv -----
// Self-checking testbench for the LED line sweep sequencer.
module tb_led_line_sweep_sequencer;
  import lsw_pkg::*;

  localparam int LINES = 128;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 100;

  typedef enum int {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_line_sweep_sequencer #(.IMAGE_LINES(LINES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sweep predictor state
  cfg_t sweep_cfg;
  logic [15:0] image [LINES];
  logic timer_on;
  logic [15:0] top_val;
  logic [15:0] tick_cnt;
  logic [15:0] periods;
  logic [15:0] short_wait;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] end_pos;
  logic forward;
  logic active;
  logic [17:0] leds;

  in_item_t pending_cmds[$];
  out_item_t led_states[$];

  int mismatches = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic in_taken = 1'b0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_t stall_mode = FLOW;

  function automatic out_item_t sweep_step(in_item_t it);
    logic [15:0] word;
    logic [POS_W-1:0] pos_n;
    logic [POS_W-1:0] end_n;
    logic done;
    case (it.cmd)
      CMD_TICK: begin
        if (timer_on) begin
          if (tick_cnt != top_val) begin
            tick_cnt = tick_cnt + 16'd1;
          end else begin
            tick_cnt = '0;
            pos_n = pos + 1'b1;
            end_n = end_pos + 1'b1;
            done = forward ? (pos >= end_pos) : (pos_n <= end_n);
            if (periods != 16'd0) begin
              periods = periods - 16'd1;
              if (periods == 16'd0) top_val = short_wait;
            end else if (done) begin
              leds = '0;
              top_val = TOP_FULL;
              active = 1'b0;
            end else begin
              word = (pos < LINES) ? image[pos] : 16'h0000;
              leds = {word[15:14], word};
              pos = forward ? pos_n : pos - 1'b1;
              top_val = sweep_cfg.ticks_per_pixel;
            end
          end
        end
      end
      CMD_WRITE: begin
        image[it.line_index] = {it.line_cb, it.line_d};
      end
      CMD_START: begin
        leds = '0;
        forward = sweep_cfg.sweep_forward;
        if (forward) begin
          pos = POS_W'(sweep_cfg.first_line);
          end_pos = POS_W'(sweep_cfg.last_line) + 1'b1;
        end else begin
          pos = POS_W'(sweep_cfg.last_line);
          end_pos = POS_W'(sweep_cfg.first_line) - 1'b1;
        end
        periods = sweep_cfg.start_delay[31:16];
        if (periods != 16'd0) begin
          top_val = TOP_FULL;
          short_wait = sweep_cfg.start_delay[15:0];
          if (short_wait < SHORT_LIMIT) begin
            top_val = TOP_FULL - TOP_SHORT_ADJ;
            short_wait = short_wait + {periods[8:0], 7'd0};
          end
        end else begin
          top_val = sweep_cfg.start_delay[15:0];
        end
        tick_cnt = '0;
        timer_on = 1'b1;
        active = 1'b1;
      end
      default: begin
      end
    endcase
    return {leds, active};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // accept input transactions and predict their results
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      led_states.push_back(sweep_step(in_item));
    end
  end

  // driver: bursts of transactions with random gaps
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        in_item <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3, 0));
      mode_left = $urandom_range(256, 32);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        FLOW:    out_stall <= 1'b0;
        LIGHT:   out_stall <= ($urandom_range(3, 0) == 0);
        HEAVY:   out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (led_states.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_item), 32'h0);
      end else begin
        want = led_states.pop_front();
        if (out_item.led_b_high !== want.led_b_high)
          report_mismatch("led_b_high", 32'(out_item.led_b_high), 32'(want.led_b_high));
        if (out_item.led_c !== want.led_c)
          report_mismatch("led_c", 32'(out_item.led_c), 32'(want.led_c));
        if (out_item.led_d !== want.led_d)
          report_mismatch("led_d", 32'(out_item.led_d), 32'(want.led_d));
        if (out_item.sweep_active !== want.sweep_active)
          report_mismatch("sweep_active", 32'(out_item.sweep_active), 32'(want.sweep_active));
      end
    end
  end

  task automatic push(logic [1:0] cmd, logic [6:0] idx, logic [7:0] cb, logic [7:0] d);
    in_item_t it;
    it.cmd = cmd;
    it.line_index = idx;
    it.line_cb = cb;
    it.line_d = d;
    pending_cmds.push_back(it);
  endtask

  task automatic push_ticks(int n, bit noisy);
    int r;
    repeat (n) begin
      r = noisy ? $urandom_range(39, 0) : 39;
      if (r < 3)
        push(CMD_WRITE, 7'($urandom()), 8'($urandom()), 8'($urandom()));
      else if (r == 3)
        push(CMD_UNUSED, 7'($urandom()), 8'($urandom()), 8'($urandom()));
      else if (r == 4)
        push(CMD_START, 7'($urandom()), 8'($urandom()), 8'($urandom()));
      else
        push(CMD_TICK, 7'($urandom()), 8'($urandom()), 8'($urandom()));
    end
  endtask

  // wait until every offered transaction is accepted and every result has come
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || (in_valid && !in_taken) || led_states.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_FIRST_LINE:      sweep_cfg.first_line = val[6:0];
      REG_LAST_LINE:       sweep_cfg.last_line = val[6:0];
      REG_SWEEP_FORWARD:   sweep_cfg.sweep_forward = val[0];
      REG_TICKS_PER_PIXEL: sweep_cfg.ticks_per_pixel = val[15:0];
      REG_START_DELAY:     sweep_cfg.start_delay = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [6:0] first, logic [6:0] last, logic fwd,
                           logic [15:0] tpp, logic [31:0] dly);
    drain();
    write_reg(REG_FIRST_LINE, 32'(first));
    write_reg(REG_LAST_LINE, 32'(last));
    write_reg(REG_SWEEP_FORWARD, 32'(fwd));
    write_reg(REG_TICKS_PER_PIXEL, 32'(tpp));
    write_reg(REG_START_DELAY, dly);
  endtask

  initial begin
    int a;
    int b;
    int n;
    int span;
    int rand_items;
    bit first_phase;
    logic [15:0] tpp;
    logic [31:0] dly;

    sweep_cfg = '{first_line: 7'd0, last_line: 7'd0, sweep_forward: 1'b1,
                  ticks_per_pixel: 16'd0, start_delay: 32'd0};
    foreach (image[i]) image[i] = '0;
    timer_on = 1'b0;
    top_val = '0;
    tick_cnt = '0;
    periods = '0;
    short_wait = '0;
    pos = '0;
    end_pos = '0;
    forward = 1'b1;
    active = 1'b0;
    leds = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ticks before any start, an unused command, then fill the image store and start a sweep
    push(CMD_TICK, 7'h7f, 8'hff, 8'hff);
    push(CMD_TICK, 7'h00, 8'h00, 8'h00);
    push(CMD_UNUSED, 7'h7f, 8'hff, 8'hff);
    for (int i = 0; i < LINES; i++)
      push(CMD_WRITE, 7'(i), 8'($urandom()), 8'($urandom()));
    push(CMD_WRITE, 7'd0, 8'hff, 8'h00);
    push(CMD_WRITE, 7'd1, 8'h00, 8'hff);
    push(CMD_WRITE, 7'd126, 8'h00, 8'h00);
    push(CMD_WRITE, 7'd127, 8'hff, 8'hff);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(4, 1'b0);

    // full range forward, restarted partway
    configure(7'd0, 7'd127, 1'b1, 16'd0, 32'd0);
    push(CMD_START, 7'h55, 8'haa, 8'h55);
    push_ticks(40, 1'b0);
    push(CMD_START, 7'h2a, 8'h55, 8'haa);
    push_ticks(132, 1'b0);

    // reversed range, backward
    configure(7'd127, 7'd0, 1'b0, 16'd1, 32'd5);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(12, 1'b0);

    // backward from the top line
    configure(7'd120, 7'd127, 1'b0, 16'd2, 32'd3);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(34, 1'b0);

    // backward down to line zero
    configure(7'd0, 7'd3, 1'b0, 16'd0, 32'd0);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(8, 1'b0);

    // reversed range, forward
    configure(7'd5, 7'd2, 1'b1, 16'd0, 32'd0);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(6, 1'b0);

    // largest timer values
    configure(7'd127, 7'd127, 1'b1, 16'hffff, 32'hffff_ffff);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(6, 1'b0);

    // one full period, short remainder adjusted
    configure(7'd3, 7'd6, 1'b1, 16'd0, 32'h0001_0040);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(20, 1'b0);

    // one full period, remainder used as is
    configure(7'd10, 7'd11, 1'b0, 16'd1, 32'h0001_0123);
    push(CMD_START, 7'd0, 8'h00, 8'h00);
    push_ticks(20, 1'b0);

    rand_items = 0;
    first_phase = 1'b1;
    while (rand_items < 270) begin
      drain();
      a = $urandom_range(127, 0);
      b = $urandom_range((a + 8 > 127) ? 127 : a + 8, a);
      if ($urandom_range(5, 0) == 0) begin
        n = a;
        a = b;
        b = n;
      end
      if ($urandom_range(3, 0) != 0) begin
        write_reg(REG_FIRST_LINE, ($urandom() << 7) | 32'(a));
        write_reg(REG_LAST_LINE, ($urandom() << 7) | 32'(b));
      end
      if ($urandom_range(1, 0) == 0)
        write_reg(REG_SWEEP_FORWARD, $urandom());
      if ($urandom_range(1, 0) == 0) begin
        tpp = ($urandom_range(11, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(3, 0));
        write_reg(REG_TICKS_PER_PIXEL, ($urandom() << 16) | 32'(tpp));
      end
      if ($urandom_range(1, 0) == 0) begin
        dly = ($urandom_range(9, 0) == 0) ? $urandom() : 32'($urandom_range(8, 0));
        write_reg(REG_START_DELAY, dly);
      end
      if (sweep_cfg.first_line > sweep_cfg.last_line)
        span = 1;
      else
        span = int'(sweep_cfg.last_line) - int'(sweep_cfg.first_line) + 2;
      n = span * (int'(sweep_cfg.ticks_per_pixel) + 1) + 4;
      if (sweep_cfg.start_delay[31:16] == 16'd0)
        n = n + int'(sweep_cfg.start_delay[15:0]);
      if (n > 100) n = 100;
      if (first_phase) begin
        first_phase = 1'b0;
        hold_request = 1'b1;
        n = 200;
      end
      if ($urandom_range(7, 0) != 0)
        push(CMD_START, 7'($urandom()), 8'($urandom()), 8'($urandom()));
      push_ticks(n, 1'b1);
      rand_items += n + 1;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lsw_pkg.sv
hdl/lsw_regs.sv
hdl/lsw_store.sv
hdl/lsw_ctrl.sv
hdl/lsw_out.sv
hdl/led_line_sweep_sequencer.sv
bench/tb_led_line_sweep_sequencer.sv
